/* rtl/gsr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gsr_pkg;

    localparam int GRID_SIZE  = 16;
    localparam int VALUE_BITS = 16;

    localparam int CELL_COUNT = GRID_SIZE * GRID_SIZE;
    localparam int CELL_BITS  = $clog2(CELL_COUNT);
    localparam int SIDE_BITS  = $clog2(GRID_SIZE + 1);
    localparam int POS_BITS   = SIDE_BITS + 1;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_ROTATE = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  row;
        logic [3:0]  column;
        logic [4:0]  square_size;
        logic        direction;
        logic [15:0] value;
    } gsr_req_t;

    typedef struct packed {
        logic [15:0] read_value;
        logic        bad_request;
    } gsr_rsp_t;

    function automatic logic [CELL_BITS-1:0] cell_index(
        input logic [POS_BITS-1:0] r,
        input logic [POS_BITS-1:0] c
    );
        cell_index = CELL_BITS'(int'(r) * GRID_SIZE + int'(c));
    endfunction

endpackage

`default_nettype wire

/* rtl/gsr_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface gsr_req_if;
    import gsr_pkg::*;
    logic     valid;
    logic     ready;
    gsr_req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gsr_rsp_if;
    import gsr_pkg::*;
    logic     valid;
    logic     ready;
    gsr_rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/grid_square_rotator_top.sv */
// write, rejection or size-one rotation: idle then done; read: idle, read, then done
// rotation: each four-cell group is read corner by corner, then written back
//   through the single grid memory, ring by ring from the outside in
// one transaction in flight: a request is taken only in the idle state;
//   the next request is taken while a result waits
// reset clears the sequencer and the result valid flag; grid contents stay undefined
`timescale 1ns / 1ps
`default_nettype none

module grid_square_rotator_top
    import gsr_pkg::*;
(
    input  wire       clk,
    input  wire       rst_n,
    gsr_req_if.sink   req,
    gsr_rsp_if.source rsp
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_ROT  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [VALUE_BITS-1:0] grid_mem [CELL_COUNT];
    logic [VALUE_BITS-1:0] rd_data_reg;
    logic [CELL_BITS-1:0]  rd_addr;
    logic [CELL_BITS-1:0]  wr_addr;
    logic [VALUE_BITS-1:0] wr_data;
    logic                  wr_en;

    logic [1:0]           state_reg, state_next;
    logic [2:0]           phase_reg, phase_next;
    logic [SIDE_BITS-1:0] ring_reg, ring_next;
    logic [SIDE_BITS-1:0] k_reg, k_next;
    logic [POS_BITS-1:0]  top_reg, top_next;
    logic [POS_BITS-1:0]  left_reg, left_next;
    logic [SIDE_BITS-1:0] side_reg, side_next;
    logic                 anti_reg, anti_next;

    logic [VALUE_BITS-1:0] va_reg, va_next;
    logic [VALUE_BITS-1:0] vb_reg, vb_next;
    logic [VALUE_BITS-1:0] vc_reg, vc_next;
    logic [VALUE_BITS-1:0] vd_reg, vd_next;

    logic                  res_bad_reg, res_bad_next;
    logic [VALUE_BITS-1:0] res_value_reg, res_value_next;
    logic                  out_valid_reg, out_valid_next;
    gsr_rsp_t              out_data_reg, out_data_next;

    logic                 cell_ok;
    logic                 square_bad;
    logic [POS_BITS-1:0]  far_pos, back_pos, ring_pos, k_pos;
    logic [POS_BITS-1:0]  corner_row, corner_col;
    logic [CELL_BITS-1:0] corner_addr;
    logic [CELL_BITS-1:0] in_addr;
    logic                 out_free;

    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    assign cell_ok    = (int'(req.data.row) < GRID_SIZE) && (int'(req.data.column) < GRID_SIZE);
    assign square_bad = (req.data.square_size == 5'd0)
                     || (int'(req.data.row) + int'(req.data.square_size) > GRID_SIZE)
                     || (int'(req.data.column) + int'(req.data.square_size) > GRID_SIZE);
    assign in_addr    = cell_index(POS_BITS'(req.data.row), POS_BITS'(req.data.column));
    assign out_free   = !out_valid_reg || rsp.ready;

    // corner coordinates of the current group
    assign ring_pos = POS_BITS'(ring_reg);
    assign k_pos    = POS_BITS'(k_reg);
    assign far_pos  = POS_BITS'(side_reg) - POS_BITS'(1) - ring_pos;
    assign back_pos = POS_BITS'(side_reg) - POS_BITS'(1) - k_pos;

    always_comb
    begin
        case (phase_reg[1:0])
            2'd0:
            begin
                corner_row = top_reg + ring_pos;
                corner_col = left_reg + k_pos;
            end
            2'd1:
            begin
                corner_row = top_reg + k_pos;
                corner_col = left_reg + far_pos;
            end
            2'd2:
            begin
                corner_row = top_reg + far_pos;
                corner_col = left_reg + back_pos;
            end
            default:
            begin
                corner_row = top_reg + back_pos;
                corner_col = left_reg + ring_pos;
            end
        endcase
    end

    assign corner_addr = cell_index(corner_row, corner_col);

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        ring_next      = ring_reg;
        k_next         = k_reg;
        top_next       = top_reg;
        left_next      = left_reg;
        side_next      = side_reg;
        anti_next      = anti_reg;
        va_next        = va_reg;
        vb_next        = vb_reg;
        vc_next        = vc_reg;
        vd_next        = vd_reg;
        res_bad_next   = res_bad_reg;
        res_value_next = res_value_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        rd_addr        = corner_addr;
        wr_addr        = corner_addr;
        wr_data        = rd_data_reg;
        wr_en          = 1'b0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                rd_addr = in_addr;
                wr_addr = in_addr;
                wr_data = VALUE_BITS'(req.data.value);
                if (req.valid)
                begin
                    res_bad_next   = 1'b0;
                    res_value_next = '0;
                    state_next     = ST_DONE;
                    case (req.data.operation)
                        OP_WRITE:
                        begin
                            wr_en        = cell_ok;
                            res_bad_next = !cell_ok;
                        end
                        OP_READ:
                        begin
                            res_bad_next = !cell_ok;
                            if (cell_ok)
                            begin
                                state_next = ST_READ;
                            end
                        end
                        OP_ROTATE:
                        begin
                            res_bad_next = square_bad;
                            top_next     = POS_BITS'(req.data.row);
                            left_next    = POS_BITS'(req.data.column);
                            side_next    = SIDE_BITS'(req.data.square_size);
                            anti_next    = req.data.direction;
                            ring_next    = '0;
                            k_next       = '0;
                            phase_next   = '0;
                            if (!square_bad && req.data.square_size > 5'd1)
                            begin
                                state_next = ST_ROT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                res_value_next = rd_data_reg;
                state_next     = ST_DONE;
            end
            ST_ROT:
            begin
                phase_next = phase_reg + 3'd1;
                case (phase_reg)
                    3'd1: va_next = rd_data_reg;
                    3'd2: vb_next = rd_data_reg;
                    3'd3: vc_next = rd_data_reg;
                    3'd4: vd_next = rd_data_reg;
                    default:
                    begin
                    end
                endcase
                if (phase_reg[2])
                begin
                    wr_en = 1'b1;
                    case (phase_reg[1:0])
                        2'd0: wr_data = anti_reg ? vb_reg : rd_data_reg;
                        2'd1: wr_data = anti_reg ? vc_reg : va_reg;
                        2'd2: wr_data = anti_reg ? vd_reg : vb_reg;
                        default: wr_data = anti_reg ? va_reg : vc_reg;
                    endcase
                end
                if (phase_reg == 3'd7)
                begin
                    // step to the next group, then the next ring inward
                    if (POS_BITS'(k_reg) + POS_BITS'(1) < far_pos)
                    begin
                        k_next = k_reg + SIDE_BITS'(1);
                    end
                    else if (ring_reg + SIDE_BITS'(1) < (side_reg >> 1))
                    begin
                        ring_next = ring_reg + SIDE_BITS'(1);
                        k_next    = ring_reg + SIDE_BITS'(1);
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            default:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.read_value = 16'(res_value_reg);
                    out_data_next.bad_request = res_bad_reg;
                    state_next               = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            grid_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= grid_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ring_reg      <= ring_next;
        k_reg         <= k_next;
        top_reg       <= top_next;
        left_reg      <= left_next;
        side_reg      <= side_next;
        anti_reg      <= anti_next;
        va_reg        <= va_next;
        vb_reg        <= vb_next;
        vc_reg        <= vc_next;
        vd_reg        <= vd_next;
        res_bad_reg   <= res_bad_next;
        res_value_reg <= res_value_next;
        out_data_reg  <= out_data_next;
    end

endmodule

`default_nettype wire

/* dv/grid_square_rotator_top_tb.sv */
`timescale 1ns / 1ps

module grid_square_rotator_top_tb
    import gsr_pkg::*;
;

    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam logic [VALUE_BITS-1:0] VALUE_MASK = VALUE_BITS'((64'd1 << VALUE_BITS) - 1);
    localparam int RANDOM_ITEMS = 890;
    localparam int HOLD_AT = 600;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic send_valid = 1'b0;
    gsr_req_t send_data = '0;
    logic take_ready = 1'b0;

    gsr_req_if req_ch ();
    gsr_rsp_if rsp_ch ();

    assign req_ch.valid = send_valid;
    assign req_ch.data = send_data;
    assign rsp_ch.ready = take_ready;

    grid_square_rotator_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    gsr_req_t pending_reqs [$];
    gsr_rsp_t expected_rsps [$];
    logic [VALUE_BITS-1:0] grid_model [CELL_COUNT];

    int items_issued = 0;
    int results_seen = 0;
    int errors = 0;
    int n_writes = 0;
    int n_reads = 0;
    int n_turns = 0;
    int n_full_turns = 0;
    int n_rejected = 0;
    int n_spare = 0;

    int send_idle = 0;
    int sink_idle = 0;
    bit send_quiet = 1'b0;
    bit sink_quiet = 1'b0;
    int quiet_cycles = 0;
    gsr_rsp_t want;

    // in-place ring rotation, four cells per group
    function automatic void turn_block(int top, int left, int side, logic anti);
        int ring;
        int k;
        int far;
        int back;
        int a;
        int b;
        int c;
        int d;
        logic [VALUE_BITS-1:0] hold;
        for (ring = 0; ring < side / 2; ring++)
        begin
            far = side - 1 - ring;
            for (k = ring; k < far; k++)
            begin
                back = side - 1 - k;
                a = (top + ring) * GRID_SIZE + left + k;
                b = (top + k) * GRID_SIZE + left + far;
                c = (top + far) * GRID_SIZE + left + back;
                d = (top + back) * GRID_SIZE + left + ring;
                hold = grid_model[a];
                if (!anti)
                begin
                    grid_model[a] = grid_model[d];
                    grid_model[d] = grid_model[c];
                    grid_model[c] = grid_model[b];
                    grid_model[b] = hold;
                end
                else
                begin
                    grid_model[a] = grid_model[b];
                    grid_model[b] = grid_model[c];
                    grid_model[c] = grid_model[d];
                    grid_model[d] = hold;
                end
            end
        end
    endfunction

    function automatic void predict_result(gsr_req_t t);
        gsr_rsp_t r;
        int idx;
        bit cell_ok;
        int side;
        r = '0;
        cell_ok = int'(t.row) < GRID_SIZE && int'(t.column) < GRID_SIZE;
        idx = int'(t.row) * GRID_SIZE + int'(t.column);
        side = int'(t.square_size);
        case (t.operation)
            OP_WRITE:
            begin
                n_writes++;
                if (cell_ok)
                    grid_model[idx] = t.value & VALUE_MASK;
                else
                    r.bad_request = 1'b1;
            end
            OP_READ:
            begin
                n_reads++;
                if (cell_ok)
                    r.read_value = 16'(grid_model[idx] & VALUE_MASK);
                else
                    r.bad_request = 1'b1;
            end
            OP_ROTATE:
            begin
                if (side == 0 || int'(t.row) + side > GRID_SIZE
                    || int'(t.column) + side > GRID_SIZE)
                begin
                    r.bad_request = 1'b1;
                    n_rejected++;
                end
                else
                begin
                    turn_block(int'(t.row), int'(t.column), side, t.direction);
                    n_turns++;
                    if (side == GRID_SIZE)
                        n_full_turns++;
                end
            end
            default:
                n_spare++;
        endcase
        expected_rsps.insert(expected_rsps.size(), r);
    endfunction

    function automatic gsr_req_t pack_req(logic [1:0] op, int r, int c, int side, logic dir,
                                          logic [15:0] v);
        gsr_req_t t;
        t.operation = op;
        t.row = 4'(r);
        t.column = 4'(c);
        t.square_size = 5'(side);
        t.direction = dir;
        t.value = v;
        return t;
    endfunction

    function automatic gsr_req_t random_req();
        gsr_req_t t;
        int pick;
        int shape;
        int side;
        t.row = 4'($urandom_range(0, 15));
        t.column = 4'($urandom_range(0, 15));
        t.square_size = 5'($urandom_range(0, 31));
        t.direction = 1'($urandom_range(0, 1));
        t.value = 16'($urandom_range(0, 65535));
        pick = $urandom_range(0, 99);
        if (pick < 28)
            t.operation = OP_WRITE;
        else if (pick < 56)
            t.operation = OP_READ;
        else if (pick < 58)
            t.operation = OP_SPARE;
        else if (pick < 90)
        begin
            t.operation = OP_ROTATE;
            shape = $urandom_range(0, 99);
            if (shape < 3)
                side = GRID_SIZE;
            else if (shape < 12)
                side = $urandom_range(7, GRID_SIZE - 1);
            else
                side = $urandom_range(1, 6);
            t.square_size = 5'(side);
            t.row = 4'($urandom_range(0, GRID_SIZE - side));
            t.column = 4'($urandom_range(0, GRID_SIZE - side));
        end
        else
        begin
            t.operation = OP_ROTATE;
            if ($urandom_range(0, 3) == 0)
                t.square_size = '0;
        end
        return t;
    endfunction

    function automatic void queue_req(gsr_req_t t);
        pending_reqs.insert(pending_reqs.size(), t);
        items_issued++;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_valid <= 1'b0;
            send_data <= '0;
            send_idle = 0;
        end
        else
        begin
            if (send_valid && req_ch.ready)
            begin
                predict_result(send_data);
                if ($urandom_range(0, 31) == 0)
                    send_quiet = !send_quiet;
                send_idle = send_quiet ? 0 : $urandom_range(0, 8);
            end
            if (!send_valid || req_ch.ready)
            begin
                if (send_idle > 0)
                begin
                    send_valid <= 1'b0;
                    send_idle--;
                end
                else if (pending_reqs.size() > 0)
                begin
                    send_valid <= 1'b1;
                    send_data <= pending_reqs.pop_front();
                end
                else
                begin
                    send_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            take_ready <= 1'b0;
            sink_idle = 0;
        end
        else
        begin
            if (rsp_ch.valid && take_ready)
            begin
                results_seen++;
                if (expected_rsps.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected transaction, expected none, actual %h/%b", $time,
                             rsp_ch.data.read_value, rsp_ch.data.bad_request);
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp_ch.data.read_value !== want.read_value)
                    begin
                        errors++;
                        $display("%0t: read_value mismatch, expected %h, actual %h", $time,
                                 want.read_value, rsp_ch.data.read_value);
                    end
                    if (rsp_ch.data.bad_request !== want.bad_request)
                    begin
                        errors++;
                        $display("%0t: bad_request mismatch, expected %b, actual %b", $time,
                                 want.bad_request, rsp_ch.data.bad_request);
                    end
                end
                if ($urandom_range(0, 31) == 0)
                    sink_quiet = !sink_quiet;
                sink_idle = sink_quiet ? 0 : $urandom_range(0, 8);
                // long back-pressure while the sender keeps going
                if (results_seen == HOLD_AT)
                    sink_idle = HOLD_CYCLES;
            end
            if (sink_idle > 0)
            begin
                take_ready <= 1'b0;
                sink_idle--;
            end
            else
            begin
                take_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((send_valid && req_ch.ready) || (rsp_ch.valid && take_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int fill_order [CELL_COUNT];
        int i;
        int j;
        int tmp;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        queue_req(pack_req(OP_WRITE, 0, 0, 0, 1'b0, 16'h0000));
        queue_req(pack_req(OP_WRITE, 0, 15, 0, 1'b0, 16'hFFFF));
        queue_req(pack_req(OP_WRITE, 15, 0, 0, 1'b0, 16'hA5A5));
        queue_req(pack_req(OP_WRITE, 15, 15, 0, 1'b0, 16'h5A5A));
        queue_req(pack_req(OP_READ, 0, 0, 0, 1'b0, 16'h0000));
        queue_req(pack_req(OP_READ, 0, 15, 0, 1'b0, 16'h0000));
        queue_req(pack_req(OP_READ, 15, 0, 0, 1'b0, 16'h0000));
        queue_req(pack_req(OP_READ, 15, 15, 0, 1'b0, 16'h0000));
        // rejected squares: size zero, too tall, too wide, off the corner, oversize
        queue_req(pack_req(OP_ROTATE, 0, 0, 0, 1'b0, 16'h0000));
        queue_req(pack_req(OP_ROTATE, 1, 0, 16, 1'b1, 16'h0000));
        queue_req(pack_req(OP_ROTATE, 15, 15, 2, 1'b0, 16'h0000));
        queue_req(pack_req(OP_ROTATE, 0, 15, 16, 1'b1, 16'h0000));
        queue_req(pack_req(OP_ROTATE, 0, 0, 31, 1'b0, 16'h0000));
        // single-cell squares leave the grid alone
        queue_req(pack_req(OP_ROTATE, 15, 15, 1, 1'b0, 16'h0000));
        queue_req(pack_req(OP_ROTATE, 15, 15, 1, 1'b1, 16'h0000));
        queue_req(pack_req(OP_READ, 15, 15, 0, 1'b0, 16'h0000));
        queue_req(pack_req(OP_SPARE, 15, 15, 31, 1'b1, 16'hFFFF));
        queue_req(pack_req(OP_WRITE, 0, 1, 0, 1'b0, 16'h1111));
        queue_req(pack_req(OP_WRITE, 1, 0, 0, 1'b0, 16'h2222));
        queue_req(pack_req(OP_WRITE, 1, 1, 0, 1'b0, 16'h3333));
        queue_req(pack_req(OP_ROTATE, 0, 0, 2, 1'b0, 16'h0000));
        queue_req(pack_req(OP_READ, 0, 0, 0, 1'b0, 16'h0000));
        queue_req(pack_req(OP_ROTATE, 0, 0, 2, 1'b1, 16'h0000));
        queue_req(pack_req(OP_READ, 0, 1, 0, 1'b0, 16'h0000));
        while (results_seen < items_issued) @(posedge clk);

        // load every cell in shuffled order
        for (i = 0; i < CELL_COUNT; i++)
            fill_order[i] = i;
        for (i = CELL_COUNT - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = fill_order[i];
            fill_order[i] = fill_order[j];
            fill_order[j] = tmp;
        end
        for (i = 0; i < CELL_COUNT; i++)
            queue_req(pack_req(OP_WRITE, fill_order[i] / GRID_SIZE, fill_order[i] % GRID_SIZE,
                               $urandom_range(0, 31), 1'($urandom_range(0, 1)),
                               16'($urandom_range(0, 65535))));
        while (results_seen < items_issued) @(posedge clk);

        for (i = 0; i < RANDOM_ITEMS; i++)
            queue_req(random_req());
        while (results_seen < items_issued) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (expected_rsps.size() != 0)
        begin
            errors++;
            $display("%0t: %0d results never arrived", $time, expected_rsps.size());
        end
        $display("covered %0d writes, %0d reads, %0d rotations (%0d full grid), %0d rejected",
                 n_writes, n_reads, n_turns, n_full_turns, n_rejected);
        $display("plus %0d unused opcodes; %0d transactions checked, %0d mismatches",
                 n_spare, results_seen, errors);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/gsr_pkg.sv
rtl/gsr_if.sv
rtl/grid_square_rotator_top.sv
dv/grid_square_rotator_top_tb.sv
